// File: hw/rtl/spg_pkg.sv
// Package for the swap permutation generator.
// Holds field widths, the microcode word format and the control program.
// Depends on nothing; every other file imports it.
`default_nettype none

package spg_pkg;

	localparam int MAX_ELEMENTS_DEF = 8;
	localparam int CFG_W            = 4;
	localparam int ELEM_W           = 4;
	localparam int WORD_W           = 32;
	localparam int WORD_POS         = WORD_W / ELEM_W;
	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(3);

	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_SET_LV,
		OP_LOAD_K,
		OP_SW_A,
		OP_SW_B,
		OP_SW_C_INC,
		OP_TEST,
		OP_DEC_LV,
		OP_SW_C_DESC,
		OP_INIT,
		OP_EXH,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_START,
		C_FIN_LV0,
		C_K_LT_N,
		C_LV0,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	localparam logic [PC_W-1:0] PC_WAIT    = PC_W'(0);
	localparam logic [PC_W-1:0] PC_CHK_RS  = PC_W'(1);
	localparam logic [PC_W-1:0] PC_CHK_FIN = PC_W'(2);
	localparam logic [PC_W-1:0] PC_LOAD_K  = PC_W'(3);
	localparam logic [PC_W-1:0] PC_UNSW_A  = PC_W'(4);
	localparam logic [PC_W-1:0] PC_UNSW_B  = PC_W'(5);
	localparam logic [PC_W-1:0] PC_UNSW_C  = PC_W'(6);
	localparam logic [PC_W-1:0] PC_TEST    = PC_W'(7);
	localparam logic [PC_W-1:0] PC_UP      = PC_W'(8);
	localparam logic [PC_W-1:0] PC_LOOP    = PC_W'(9);
	localparam logic [PC_W-1:0] PC_SW_A    = PC_W'(10);
	localparam logic [PC_W-1:0] PC_SW_B    = PC_W'(11);
	localparam logic [PC_W-1:0] PC_SW_C    = PC_W'(12);
	localparam logic [PC_W-1:0] PC_INIT    = PC_W'(13);
	localparam logic [PC_W-1:0] PC_EXH     = PC_W'(14);
	localparam logic [PC_W-1:0] PC_EMIT    = PC_W'(15);

	// A step jumps to its target when its condition holds, else falls to the next step.
	// The emit step is last, so falling through it wraps back to the wait step.
	function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			PC_WAIT:    w = '{OP_CAPTURE,   C_NO_REQ,   PC_WAIT};
			PC_CHK_RS:  w = '{OP_NOP,       C_START,    PC_INIT};
			PC_CHK_FIN: w = '{OP_SET_LV,    C_FIN_LV0,  PC_EXH};
			PC_LOAD_K:  w = '{OP_LOAD_K,    C_NEVER,    PC_WAIT};
			PC_UNSW_A:  w = '{OP_SW_A,      C_NEVER,    PC_WAIT};
			PC_UNSW_B:  w = '{OP_SW_B,      C_NEVER,    PC_WAIT};
			PC_UNSW_C:  w = '{OP_SW_C_INC,  C_NEVER,    PC_WAIT};
			PC_TEST:    w = '{OP_TEST,      C_K_LT_N,   PC_SW_A};
			PC_UP:      w = '{OP_DEC_LV,    C_LV0,      PC_EXH};
			PC_LOOP:    w = '{OP_NOP,       C_ALWAYS,   PC_LOAD_K};
			PC_SW_A:    w = '{OP_SW_A,      C_NEVER,    PC_WAIT};
			PC_SW_B:    w = '{OP_SW_B,      C_NEVER,    PC_WAIT};
			PC_SW_C:    w = '{OP_SW_C_DESC, C_ALWAYS,   PC_EMIT};
			PC_INIT:    w = '{OP_INIT,      C_ALWAYS,   PC_EMIT};
			PC_EXH:     w = '{OP_EXH,       C_NEVER,    PC_WAIT};
			PC_EMIT:    w = '{OP_EMIT,      C_OUT_BUSY, PC_EMIT};
			default:    w = '{OP_NOP,       C_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spg_if.sv
// Channel interfaces of the swap permutation generator: request, result and size write.
// Depends on spg_pkg for the field widths.
`default_nettype none

interface spg_in_if import spg_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface spg_out_if import spg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] perm_word;
	logic              is_last;
	logic              exhausted;

	modport source (output valid, output perm_word, output is_last, output exhausted,
		input ready);
	modport sink (input valid, input perm_word, input is_last, input exhausted,
		output ready);
endinterface

interface spg_cfg_if import spg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] set_size;

	modport source (output valid, output set_size, input ready);
	modport sink (input valid, input set_size, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swap_permutation_generator.sv
// Swap permutation generator: a microcoded sequencer over an element and loop index file.
// Depends on spg_pkg and the channel interfaces in spg_if.
// One request is in work at a time; the next is taken while the result waits. A stalled result
// holds the emit step. Reset loads the identity, size 3; size writes are taken only when idle.
`default_nettype none

module swap_permutation_generator import spg_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	spg_cfg_if.sink   cfg,
	spg_in_if.sink    req,
	spg_out_if.source rsp
);

	localparam int IW   = $clog2(MAX_ELEMENTS);
	localparam int NW   = $clog2(MAX_ELEMENTS + 1);
	localparam int PACK = (MAX_ELEMENTS < WORD_POS) ? MAX_ELEMENTS : WORD_POS;
	localparam logic [CFG_W-1:0] MAX_C = CFG_W'(MAX_ELEMENTS);

	logic [CFG_W-1:0]  size_q;
	logic [ELEM_W-1:0] elem_q [MAX_ELEMENTS];
	logic [IW-1:0]     lidx_q [MAX_ELEMENTS];
	logic [IW-1:0]     level_q;
	logic [IW-1:0]     lv_q;
	logic [NW-1:0]     k_q;
	logic [ELEM_W-1:0] t_q;
	logic              started_q;
	logic              finished_q;
	logic              rs_q;
	logic [PC_W-1:0]   pc_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;
	logic              out_exh_q;

	ctrl_word_t        cw;
	logic [NW-1:0]     n_c;
	logic [IW-1:0]     n_m1;
	logic [IW-1:0]     rd_addr;
	logic [ELEM_W-1:0] rd_data;
	logic [IW-1:0]     lidx_rd;
	logic              k_lt_n;
	logic              out_busy;
	logic              cond_ok;
	logic [PC_W-1:0]   pc_next;
	logic [WORD_W-1:0] perm_c;
	logic              last_c;
	logic              req_fire;
	logic              cfg_fire;

	assign cw       = prog_rom(pc_q);
	assign req_fire = req.valid && req.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign out_busy = out_valid_q && !rsp.ready;
	assign k_lt_n   = k_q < n_c;
	assign n_m1     = IW'(n_c - NW'(1));
	assign rd_addr  = (cw.op == OP_SW_A) ? k_q[IW-1:0] : lv_q;
	assign rd_data  = elem_q[rd_addr];
	assign lidx_rd  = lidx_q[lv_q];

	always_comb begin
		if (size_q == '0) begin
			n_c = NW'(1);
		end else if (size_q > MAX_C) begin
			n_c = NW'(MAX_ELEMENTS);
		end else begin
			n_c = NW'(size_q);
		end
	end

	always_comb begin
		perm_c = '0;
		for (int i = 0; i < PACK; i++) begin
			if (NW'(i) < n_c) begin
				perm_c[ELEM_W*i +: ELEM_W] = elem_q[i];
			end
		end
	end

	always_comb begin
		last_c = 1'b1;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			if ((NW'(i) + NW'(1)) < n_c && lidx_q[i] != n_m1) begin
				last_c = 1'b0;
			end
		end
	end

	always_comb begin
		case (cw.cond)
			C_NEVER:    cond_ok = 1'b0;
			C_ALWAYS:   cond_ok = 1'b1;
			C_NO_REQ:   cond_ok = !req.valid;
			C_START:    cond_ok = rs_q || !started_q;
			C_FIN_LV0:  cond_ok = finished_q || level_q == '0;
			C_K_LT_N:   cond_ok = k_lt_n;
			C_LV0:      cond_ok = lv_q == '0;
			C_OUT_BUSY: cond_ok = out_busy;
			default:    cond_ok = 1'b0;
		endcase
		pc_next = cond_ok ? cw.target : pc_q + PC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_RESET;
			level_q     <= '0;
			lv_q        <= '0;
			k_q         <= '0;
			t_q         <= '0;
			started_q   <= 1'b0;
			finished_q  <= 1'b0;
			rs_q        <= 1'b0;
			pc_q        <= PC_WAIT;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_ELEMENTS; i++) begin
				elem_q[i] <= ELEM_W'(i + 1);
				lidx_q[i] <= '0;
			end
		end else begin
			pc_q <= pc_next;
			if (cw.op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (cw.op)
				OP_CAPTURE: begin
					if (req_fire) begin
						rs_q <= req.restart;
					end
				end
				OP_SET_LV: lv_q <= level_q - IW'(1);
				OP_LOAD_K: k_q <= NW'(lidx_rd);
				OP_SW_A: t_q <= rd_data;
				OP_SW_B: elem_q[k_q[IW-1:0]] <= rd_data;
				OP_SW_C_INC: begin
					elem_q[lv_q] <= t_q;
					k_q          <= k_q + NW'(1);
				end
				OP_TEST: lidx_q[lv_q] <= k_lt_n ? k_q[IW-1:0] : lv_q;
				OP_DEC_LV: lv_q <= lv_q - IW'(1);
				OP_SW_C_DESC: begin
					elem_q[lv_q] <= t_q;
					for (int i = 0; i < MAX_ELEMENTS; i++) begin
						if (IW'(i) > lv_q && (NW'(i) + NW'(1)) < n_c) begin
							lidx_q[i] <= IW'(i);
						end
					end
					level_q <= n_m1;
				end
				OP_INIT: begin
					for (int i = 0; i < MAX_ELEMENTS; i++) begin
						elem_q[i] <= ELEM_W'(i + 1);
						lidx_q[i] <= ((NW'(i) + NW'(1)) < n_c) ? IW'(i) : '0;
					end
					level_q    <= n_m1;
					started_q  <= 1'b1;
					finished_q <= 1'b0;
				end
				OP_EXH: finished_q <= 1'b1;
				default: begin
				end
			endcase
			if (cfg_fire) begin
				size_q     <= cfg.set_size;
				level_q    <= '0;
				started_q  <= 1'b0;
				finished_q <= 1'b0;
				for (int i = 0; i < MAX_ELEMENTS; i++) begin
					elem_q[i] <= ELEM_W'(i + 1);
					lidx_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && !out_busy) begin
			out_word_q <= finished_q ? '0 : perm_c;
			out_last_q <= finished_q ? 1'b0 : last_c;
			out_exh_q  <= finished_q;
		end
	end

	assign req.ready     = (pc_q == PC_WAIT);
	assign cfg.ready     = (pc_q == PC_WAIT) && !req.valid;
	assign rsp.valid     = out_valid_q;
	assign rsp.perm_word = out_word_q;
	assign rsp.is_last   = out_last_q;
	assign rsp.exhausted = out_exh_q;

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q) == PC_EMIT)
		else $error("result raised outside the emit step");

	a_request_leaves_wait: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> pc_q == PC_CHK_RS)
		else $error("accepted request did not start the program");

	a_exhausted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.exhausted) |-> (rsp.perm_word == '0 && !rsp.is_last))
		else $error("exhaustion report carries an ordering");

	a_finished_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> started_q)
		else $error("enumeration finished without a start");

endmodule

`default_nettype wire

// File: tb/sv/tb_swap_permutation_generator.sv
// Testbench for swap_permutation_generator. It predicts every ordering and compares it
// with the result channel while both channel ends stall at random.
// Depends on spg_pkg, the channel interfaces in spg_if and the generator RTL.
`default_nettype none

module tb_swap_permutation_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import spg_pkg::*;

	localparam int N_MAX        = MAX_ELEMENTS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 12 + 7 * (N_MAX - 2) + 8;
	localparam int MAX_GAP      = 20;

	typedef struct packed {
		logic [WORD_W-1:0] perm_word;
		logic              is_last;
		logic              exhausted;
	} ordering_t;

	logic clk;
	logic arst_n;

	spg_cfg_if cfg_ch ();
	spg_in_if  req_ch ();
	spg_out_if rsp_ch ();

	swap_permutation_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ordering_t pending_orderings[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        src_idle_pct = 0;
	int        sink_idle_pct = 0;

	logic [CFG_W-1:0]  gen_size;
	logic [ELEM_W-1:0] gen_elem [N_MAX];
	logic [3:0]        gen_k [N_MAX];
	int                gen_level;
	bit                gen_started;
	bit                gen_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic int active_size();
		int n;
		n = int'(gen_size);
		if (n < 1) n = 1;
		if (n > N_MAX) n = N_MAX;
		return n;
	endfunction

	function automatic void swap_positions(int p, int q);
		logic [ELEM_W-1:0] t;
		t = gen_elem[p];
		gen_elem[p] = gen_elem[q];
		gen_elem[q] = t;
	endfunction

	function automatic void load_identity_order();
		for (int i = 0; i < N_MAX; i++) begin
			gen_elem[i] = ELEM_W'(i + 1);
			gen_k[i] = '0;
		end
		gen_level = 0;
	endfunction

	function automatic void descend_to_leaf(int lv, int n);
		while (lv + 1 < n) begin
			gen_k[lv] = 4'(lv);
			lv++;
		end
		gen_level = lv;
	endfunction

	function automatic ordering_t current_ordering(int n);
		ordering_t r;
		r = '{perm_word: '0, is_last: 1'b1, exhausted: 1'b0};
		for (int i = 0; i < n && i < WORD_POS; i++)
			r.perm_word |= WORD_W'(gen_elem[i]) << (ELEM_W * i);
		for (int i = 0; i + 1 < n; i++)
			if (int'(gen_k[i]) != n - 1) r.is_last = 1'b0;
		return r;
	endfunction

	function automatic bit step_to_next(int n);
		int lv;
		int k;
		lv = gen_level;
		if (lv == 0) return 1'b0;
		lv--;
		while (1'b1) begin
			k = int'(gen_k[lv]);
			swap_positions(k, lv);
			k++;
			if (k < n) begin
				gen_k[lv] = 4'(k);
				swap_positions(k, lv);
				descend_to_leaf(lv + 1, n);
				return 1'b1;
			end
			gen_k[lv] = 4'(lv);
			if (lv == 0) return 1'b0;
			lv--;
		end
		return 1'b0;
	endfunction

	function automatic ordering_t predict_ordering(bit restart);
		ordering_t r;
		int n;
		n = active_size();
		r = '{perm_word: '0, is_last: 1'b0, exhausted: 1'b1};
		if (restart || !gen_started) begin
			load_identity_order();
			descend_to_leaf(0, n);
			gen_started = 1'b1;
			gen_done = 1'b0;
			r = current_ordering(n);
		end else if (!gen_done) begin
			if (step_to_next(n)) r = current_ordering(n);
			else gen_done = 1'b1;
		end
		return r;
	endfunction

	function automatic void apply_size(logic [CFG_W-1:0] value);
		gen_size = value;
		load_identity_order();
		gen_started = 1'b0;
		gen_done = 1'b0;
	endfunction

	always @(posedge clk) begin : check_result
		ordering_t got;
		ordering_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.perm_word, rsp_ch.is_last, rsp_ch.exhausted};
			if (pending_orderings.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: word=%h last=%b exhausted=%b",
					$time, got.perm_word, got.is_last, got.exhausted);
			end else begin
				want = pending_orderings.pop_front();
				if (got.perm_word !== want.perm_word || got.is_last !== want.is_last ||
					got.exhausted !== want.exhausted) begin
					mismatches++;
					$display("%0t mismatch: expected %h/%b/%b, actual %h/%b/%b",
						$time, want.perm_word, want.is_last, want.exhausted,
						got.perm_word, got.is_last, got.exhausted);
				end
			end
		end
	end

	task automatic send_request(input bit restart);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart;
		do @(posedge clk); while (!req_ch.ready);
		pending_orderings.push_back(predict_ordering(restart));
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_orderings.size() != 0);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.set_size <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		apply_size(value);
	endtask

	// Default size of three: the first advance starts the run, then exhaustion and a restart.
	task automatic test_power_on_size();
		repeat (7) send_request(1'b0);
		send_request(1'b1);
	endtask

	task automatic test_size_extremes();
		write_size(CFG_W'(0));
		send_request(1'b0);
		send_request(1'b0);
		write_size(CFG_W'(15));
		send_request(1'b1);
		send_request(1'b0);
		write_size(CFG_W'(8));
		send_request(1'b0);
		send_request(1'b1);
		write_size(CFG_W'(1));
		send_request(1'b1);
		send_request(1'b0);
	endtask

	task automatic test_size_change_mid_run();
		write_size(CFG_W'(4));
		repeat (3) send_request(1'b0);
		write_size(CFG_W'(2));
		repeat (3) send_request(1'b0);
	endtask

	task automatic test_random_orderings(input int items);
		int               sent;
		int               seg_len;
		int               n;
		int               count;
		int               restart_pct;
		logic [CFG_W-1:0] size;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(99) < 80) size = CFG_W'($urandom_range(5, 0));
			else size = CFG_W'($urandom_range(15, 6));
			write_size(size);
			n = active_size();
			if (n <= 4) begin
				count = 1;
				for (int i = 2; i <= n; i++) count *= i;
				seg_len = count + int'($urandom_range(3, 1));
			end else begin
				seg_len = int'($urandom_range(30, 8));
			end
			restart_pct = ($urandom_range(9) == 0) ? 50 : 3;
			repeat (seg_len) begin
				send_request($urandom_range(99) < restart_pct);
				sent++;
				if ($urandom_range(99) == 0) wait_idle();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.restart = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.set_size = '0;
		rsp_ch.ready = 1'b0;
		apply_size(SIZE_RESET);
		src_idle_pct = 6;
		sink_idle_pct = 73;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_size();
		test_size_extremes();
		test_size_change_mid_run();
		test_random_orderings(160);
		src_idle_pct = 73;
		sink_idle_pct = 6;
		test_random_orderings(185);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_orderings(185);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
